// File: sv/ktl_pkg.sv
`timescale 1ns / 1ps
package ktl_pkg;

  // APB address width: byte address 4*i, bit 2 selects the register slot.
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] RegMaxGapAddr = 3'd0;
  localparam logic [15:0] MaxGapReset = 16'd10000;

  // Message type coding shared by rx_type and tx_type.
  localparam logic [7:0] RxToOff = 8'd0;
  localparam logic [7:0] RxToOn  = 8'd1;
  localparam logic [7:0] RxIsOff = 8'd2;
  localparam logic [7:0] RxIsOn  = 8'd3;
  localparam logic [7:0] RxQuery = 8'd4;

  localparam logic [2:0] TxToOff = 3'd0;
  localparam logic [2:0] TxToOn  = 3'd1;
  localparam logic [2:0] TxIsOff = 3'd2;
  localparam logic [2:0] TxIsOn  = 3'd3;

  typedef enum logic [1:0] {
    KindTick = 2'd0,
    KindKey  = 2'd1,
    KindRx   = 2'd2,
    KindNone = 2'd3
  } kind_e;

  // Classified operation handed from the front to the back.
  typedef enum logic [2:0] {
    OpTick    = 3'd0,
    OpKey     = 3'd1,
    OpRxTrans = 3'd2,
    OpRxOff   = 3'd3,
    OpRxOn    = 3'd4,
    OpRxQuery = 3'd5,
    OpRxOther = 3'd6,
    OpIdle    = 3'd7
  } op_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic        key_level;
    logic [7:0]  rx_seq;
    logic [7:0]  rx_type;
    logic [15:0] rx_period;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  tx_seq;
    logic [2:0]  tx_type;
    logic [15:0] tx_period;
    logic        tone_on;
    logic [7:0]  missed_count;
    logic        rx_refused;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic        level;      // key level, or target level of a transition
    logic [7:0]  rx_seq;
    logic [15:0] rx_period;
  } cmd_t;

endpackage

// File: sv/ktl_stream_if.sv
`timescale 1ns / 1ps
interface ktl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ktl_front.sv
`timescale 1ns / 1ps
module ktl_front
  import ktl_pkg::*;
(
  ktl_stream_if.sink in_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  // Accept whenever the queue has room; decode the item into one operation.
  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;

  always_comb begin
    cmd_o.level     = in_i.data.key_level;
    cmd_o.rx_seq    = in_i.data.rx_seq;
    cmd_o.rx_period = in_i.data.rx_period;
    cmd_o.op        = OpIdle;
    case (kind_e'(in_i.data.kind))
      KindTick: cmd_o.op = OpTick;
      KindKey:  cmd_o.op = OpKey;
      KindRx: begin
        case (in_i.data.rx_type)
          RxToOff, RxToOn: begin
            cmd_o.op    = OpRxTrans;
            cmd_o.level = in_i.data.rx_type[0];
          end
          RxIsOff: cmd_o.op = OpRxOff;
          RxIsOn:  cmd_o.op = OpRxOn;
          RxQuery: cmd_o.op = OpRxQuery;
          default: cmd_o.op = OpRxOther;
        endcase
      end
      default: cmd_o.op = OpIdle;
    endcase
  end

endmodule

// File: sv/ktl_queue.sv
`timescale 1ns / 1ps
module ktl_queue
  import ktl_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/ktl_back.sv
`timescale 1ns / 1ps
module ktl_back
  import ktl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] max_gap_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  ktl_stream_if.source out_o
);

  logic [31:0] now_q, now_d;
  logic [31:0] last_edge_q, last_edge_d;
  logic        last_key_q, last_key_d;
  logic [7:0]  tx_cnt_q, tx_cnt_d;
  logic [7:0]  last_rx_q, last_rx_d;
  logic        pend_q, pend_d;
  logic        pend_lvl_q, pend_lvl_d;
  logic [31:0] due_q, due_d;
  logic [31:0] rbase_q, rbase_d;
  logic        tone_q, tone_d;
  logic        out_valid_q;
  out_item_t   out_q, res;
  logic        exec;
  logic        is_rx;
  logic [31:0] gap;

  // Execute when the output register is free or being drained this cycle.
  assign cmd_ready_o = !out_valid_q || out_o.ready;
  assign exec        = cmd_valid_i && cmd_ready_o;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign is_rx = (cmd_i.op == OpRxTrans) || (cmd_i.op == OpRxOff) || (cmd_i.op == OpRxOn) ||
                 (cmd_i.op == OpRxQuery) || (cmd_i.op == OpRxOther);

  always_comb begin
    now_d       = now_q;
    last_edge_d = last_edge_q;
    last_key_d  = last_key_q;
    tx_cnt_d    = tx_cnt_q;
    last_rx_d   = last_rx_q;
    pend_d      = pend_q;
    pend_lvl_d  = pend_lvl_q;
    due_d       = due_q;
    rbase_d     = rbase_q;
    tone_d      = tone_q;
    res         = '0;

    if (cmd_i.op == OpTick) begin
      now_d = now_q + 32'd1;
    end

    // Key edge: gap is zero on clock wrap or when above the limit.
    gap = now_d - last_edge_q;
    if (cmd_i.op == OpKey && cmd_i.level != last_key_q) begin
      res.send_valid = 1'b1;
      res.tx_seq     = tx_cnt_q;
      res.tx_type    = cmd_i.level ? TxToOn : TxToOff;
      if (last_edge_q > now_d || gap > {16'd0, max_gap_i}) begin
        res.tx_period = '0;
      end else begin
        res.tx_period = gap[15:0];
      end
      tx_cnt_d    = tx_cnt_q + 8'd1;
      last_key_d  = cmd_i.level;
      last_edge_d = now_d;
    end

    // Scheduled tone change falls due.
    if (pend_q && now_d >= due_q) begin
      tone_d  = pend_lvl_q;
      pend_d  = 1'b0;
      rbase_d = now_d;
    end

    if (is_rx) begin
      if (pend_d) begin
        res.rx_refused = 1'b1;
      end else begin
        res.missed_count = cmd_i.rx_seq - last_rx_q - 8'd1;
        last_rx_d        = cmd_i.rx_seq;
        case (cmd_i.op)
          OpRxTrans: begin
            pend_lvl_d = cmd_i.level;
            due_d      = rbase_d + {16'd0, cmd_i.rx_period};
            pend_d     = 1'b1;
          end
          OpRxOff: tone_d = 1'b0;
          OpRxOn:  tone_d = 1'b1;
          OpRxQuery: begin
            res.send_valid = 1'b1;
            res.tx_seq     = tx_cnt_q;
            res.tx_type    = last_key_q ? TxIsOn : TxIsOff;
            tx_cnt_d       = tx_cnt_q + 8'd1;
          end
          default: ;
        endcase
      end
    end

    res.tone_on = tone_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      last_edge_q <= '0;
      last_key_q  <= 1'b0;
      tx_cnt_q    <= '0;
      last_rx_q   <= '0;
      pend_q      <= 1'b0;
      pend_lvl_q  <= 1'b0;
      due_q       <= '0;
      rbase_q     <= '0;
      tone_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        now_q       <= now_d;
        last_edge_q <= last_edge_d;
        last_key_q  <= last_key_d;
        tx_cnt_q    <= tx_cnt_d;
        last_rx_q   <= last_rx_d;
        pend_q      <= pend_d;
        pend_lvl_q  <= pend_lvl_d;
        due_q       <= due_d;
        rbase_q     <= rbase_d;
        tone_q      <= tone_d;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_q <= res;
    end
  end

endmodule

// File: sv/key_timing_link_controller_core.sv
`timescale 1ns / 1ps
// Key timing link controller. Takes one item per clock cycle (tick, key
// sample or received message) while the output is not stalled and returns
// exactly one result item for each, in order. An accepted item lands in a
// small command queue the same edge; the executor pops it from the queue
// and writes its result into the output register. Sustained rate is one item
// per cycle while the output is not stalled, set by the executor, which
// updates the clock, edge timing, sequence and tone state for each item.
// A stalled output fills the queue (QueueDepth entries) before in_i.ready
// drops. The one register, max_gap_ms, sits at APB byte address 0 and is
// meant to be written while the block is idle.
module key_timing_link_controller_core
  import ktl_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ktl_stream_if.sink          in_i,
  ktl_stream_if.source        out_o,
  // APB-style configuration port
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [31:0]         pwdata_i,
  output logic [31:0]         prdata_o,
  output logic                pready_o
);

  logic [15:0] max_gap_q;
  logic        cfg_wr;
  logic        reg_sel;

  // front -> queue
  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  // queue -> back
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // Config register: only slot 0 is implemented, other slots read zero.
  assign pready_o = 1'b1;
  assign reg_sel  = (paddr_i[CfgAddrW-1] == RegMaxGapAddr[CfgAddrW-1]);
  assign cfg_wr   = psel_i && penable_i && pwrite_i && reg_sel;
  assign prdata_o = reg_sel ? {16'd0, max_gap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q <= MaxGapReset;
    end else if (cfg_wr) begin
      max_gap_q <= pwdata_i[15:0];
    end
  end

  // Front end: accept and classify.
  ktl_front u_front (
    .in_i        (in_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  // Decoupling queue.
  ktl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_cmd)
  );

  // Back end: execute and register the result.
  ktl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_gap_i   (max_gap_q),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  // A full queue always has something for the back end.
  a_full_has_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fq_ready |-> qb_valid)
    else $error("queue reports full but empty");

  // A new result only appears after a command was popped.
  a_result_from_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(qb_valid && qb_ready))
    else $error("result without executed command");

  // Register write takes effect on the next cycle.
  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> max_gap_q == $past(pwdata_i[15:0]))
    else $error("max_gap write lost");
`endif

endmodule

// File: tb/sv/key_timing_link_controller_core_tb.sv
`timescale 1ns / 1ps
module key_timing_link_controller_core_tb;
  import ktl_pkg::*;

  localparam int unsigned IdlePct    = 19;
  localparam int unsigned StallLimit = 2000;  // cycles with no handshake or register write
  localparam int unsigned TailCycles = 20;    // settle time after the last result

  logic clk_i;
  logic rst_ni;

  ktl_stream_if #(.payload_t(in_item_t))  in_if ();
  ktl_stream_if #(.payload_t(out_item_t)) out_if ();

  logic                psel_i;
  logic                penable_i;
  logic                pwrite_i;
  logic [CfgAddrW-1:0] paddr_i;
  logic [31:0]         pwdata_i;
  logic [31:0]         prdata_o;
  logic                pready_o;

  key_timing_link_controller_core DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // Items waiting for the driver, and results predicted for accepted items.
  in_item_t  link_item_q[$];
  out_item_t link_result_q[$];

  int unsigned mismatches;
  int unsigned stall_cycles;
  logic        in_fire;   // item taken at the last rising edge
  logic        no_gaps;   // both sides run flat out while set

  // Predictor state, mirrors the controller after reset.
  logic [15:0] gap_limit;
  logic [31:0] clk_ms;
  logic [31:0] edge_ms;
  logic        key_down;
  logic [7:0]  tx_seq_next;
  logic [7:0]  rx_seq_last;
  logic        chg_pending;
  logic        chg_level;
  logic [31:0] chg_due;
  logic [31:0] base_ms;
  logic        tone;

  // Sequence byte the stimulus generator hands out next.
  logic [7:0]  gen_seq;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Work out the result one item causes and advance the predicted state.
  function automatic out_item_t predict_link_result(input in_item_t it);
    out_item_t   r;
    logic [31:0] gap;
    r = '0;
    if (it.kind == KindTick) clk_ms = clk_ms + 32'd1;

    // Key edge: report direction and time since the previous edge.
    if (it.kind == KindKey && it.key_level != key_down) begin
      if (edge_ms > clk_ms) begin
        r.tx_period = '0;  // clock wrapped
      end else begin
        gap = clk_ms - edge_ms;
        r.tx_period = (gap > {16'd0, gap_limit}) ? 16'd0 : gap[15:0];
      end
      r.send_valid = 1'b1;
      r.tx_seq     = tx_seq_next;
      r.tx_type    = it.key_level ? TxToOn : TxToOff;
      tx_seq_next  = tx_seq_next + 8'd1;
      key_down     = it.key_level;
      edge_ms      = clk_ms;
    end

    // A scheduled tone change lands before any message is looked at.
    if (chg_pending && clk_ms >= chg_due) begin
      tone        = chg_level;
      chg_pending = 1'b0;
      base_ms     = clk_ms;
    end

    if (it.kind == KindRx) begin
      if (chg_pending) begin
        r.rx_refused = 1'b1;
      end else begin
        r.missed_count = it.rx_seq - rx_seq_last - 8'd1;
        rx_seq_last    = it.rx_seq;
        case (it.rx_type)
          RxToOff, RxToOn: begin
            chg_level   = it.rx_type[0];
            chg_due     = base_ms + {16'd0, it.rx_period};
            chg_pending = 1'b1;
          end
          RxIsOff: tone = 1'b0;
          RxIsOn:  tone = 1'b1;
          RxQuery: begin
            r.send_valid = 1'b1;
            r.tx_seq     = tx_seq_next;
            r.tx_type    = key_down ? TxIsOn : TxIsOff;
            tx_seq_next  = tx_seq_next + 8'd1;
          end
          default: ;  // unknown type: sequence bookkeeping only
        endcase
      end
    end
    r.tone_on = tone;
    return r;
  endfunction

  function automatic in_item_t link_item(input kind_e k, input logic lvl, input logic [7:0] seq,
                                         input logic [7:0] typ, input logic [15:0] per);
    in_item_t it;
    it.kind      = k;
    it.key_level = lvl;
    it.rx_seq    = seq;
    it.rx_type   = typ;
    it.rx_period = per;
    return it;
  endfunction

  // Mostly ticks, key samples and in-order messages with short delays;
  // unused fields carry noise.
  function automatic in_item_t random_link_item();
    in_item_t    it;
    int unsigned roll;
    it.kind      = KindTick;
    it.key_level = 1'($urandom_range(1));
    it.rx_seq    = 8'($urandom);
    it.rx_type   = 8'($urandom);
    it.rx_period = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 35) begin
      it.kind = KindTick;
    end else if (roll < 65) begin
      it.kind = KindKey;
    end else if (roll < 95) begin
      it.kind = KindRx;
      if ($urandom_range(9) != 0) gen_seq = gen_seq + 8'd1;
      else gen_seq = 8'($urandom);
      it.rx_seq = gen_seq;
      if ($urandom_range(4) != 0) it.rx_type = 8'($urandom_range(RxQuery));
      else it.rx_type = 8'($urandom_range(255, RxQuery + 1));
      roll = $urandom_range(99);
      // Keep delays short so that messages are not refused for long.
      if (roll < 70) it.rx_period = 16'($urandom_range(8));
      else if (roll < 95) it.rx_period = 16'($urandom_range(40));
      else it.rx_period = 16'($urandom_range(150));
    end else begin
      it.kind = KindNone;
    end
    return it;
  endfunction

  task automatic queue_random(input int unsigned n);
    repeat (n) link_item_q.push_back(random_link_item());
  endtask

  // Wait until every queued item is taken and every result has come back.
  task automatic drain();
    while (link_item_q.size() != 0 || in_if.valid || link_result_q.size() != 0)
      @(posedge clk_i);
  endtask

  // APB write of max_gap_ms: setup phase, then access phase until pready.
  task automatic write_max_gap(input logic [15:0] val);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= RegMaxGapAddr;
    pwdata_i  <= {16'd0, val};
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    gap_limit = val;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: a new item goes out at the falling edge once the previous one
  // was taken, unless this cycle is picked as an idle one.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_fire) begin
        if (link_item_q.size() != 0 && (no_gaps || $urandom_range(99) >= IdlePct)) begin
          in_if.valid <= 1'b1;
          in_if.data  <= link_item_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= no_gaps || ($urandom_range(99) >= IdlePct);
    end
  end

  // Monitor: predict on every accepted item, check every accepted result.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      in_fire <= in_if.valid && in_if.ready;

      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (link_result_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, got);
          mismatches++;
        end else begin
          want = link_result_q.pop_front();
          check_field("send_valid",   16'(want.send_valid),   16'(got.send_valid));
          check_field("tx_seq",       16'(want.tx_seq),       16'(got.tx_seq));
          check_field("tx_type",      16'(want.tx_type),      16'(got.tx_type));
          check_field("tx_period",    want.tx_period,         got.tx_period);
          check_field("tone_on",      16'(want.tone_on),      16'(got.tone_on));
          check_field("missed_count", 16'(want.missed_count), 16'(got.missed_count));
          check_field("rx_refused",   16'(want.rx_refused),   16'(got.rx_refused));
        end
      end

      if (in_if.valid && in_if.ready)
        link_result_q.push_back(predict_link_result(in_if.data));

      // Watchdog: any handshake or register write counts as progress.
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel_i && penable_i && pwrite_i && pready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    psel_i       = 1'b0;
    penable_i    = 1'b0;
    pwrite_i     = 1'b0;
    paddr_i      = RegMaxGapAddr;
    pwdata_i     = '0;
    in_fire      = 1'b0;
    no_gaps      = 1'b0;
    mismatches   = 0;
    stall_cycles = 0;
    gen_seq      = '0;

    gap_limit   = MaxGapReset;
    clk_ms      = '0;
    edge_ms     = '0;
    key_down    = 1'b0;
    tx_seq_next = '0;
    rx_seq_last = '0;
    chg_pending = 1'b0;
    chg_level   = 1'b0;
    chg_due     = '0;
    base_ms     = '0;
    tone        = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: key edges and their gaps, every message type, a skipped and a
    // wrapped sequence byte, a change while one is pending, unknown types,
    // the unused kind.
    link_item_q.push_back(link_item(KindKey,  1'b0, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindTick, 1'b1, 8'hff,  8'hff,   16'hffff));
    link_item_q.push_back(link_item(KindTick, 1'b0, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindKey,  1'b1, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindKey,  1'b1, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindTick, 1'b0, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindKey,  1'b0, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindRx,   1'b0, 8'd1,   RxIsOn,  16'd0));
    link_item_q.push_back(link_item(KindRx,   1'b0, 8'd5,   RxIsOff, 16'd0));
    link_item_q.push_back(link_item(KindRx,   1'b0, 8'd4,   RxQuery, 16'd0));
    link_item_q.push_back(link_item(KindKey,  1'b1, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindRx,   1'b1, 8'd5,   RxQuery, 16'hffff));
    link_item_q.push_back(link_item(KindRx,   1'b0, 8'd6,   RxToOff, 16'd0));
    link_item_q.push_back(link_item(KindRx,   1'b0, 8'd7,   RxToOn,  16'd3));
    link_item_q.push_back(link_item(KindRx,   1'b0, 8'd8,   RxIsOff, 16'd0));
    link_item_q.push_back(link_item(KindTick, 1'b0, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindTick, 1'b0, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindTick, 1'b0, 8'd0,   8'd0,    16'd0));
    link_item_q.push_back(link_item(KindRx,   1'b0, 8'hff,  8'hff,   16'hffff));
    link_item_q.push_back(link_item(KindRx,   1'b0, 8'd0,   RxQuery + 8'd1, 16'd0));
    link_item_q.push_back(link_item(KindNone, 1'b1, 8'hff,  8'hff,   16'hffff));
    link_item_q.push_back(link_item(KindKey,  1'b0, 8'hff,  8'hff,   16'hffff));
    gen_seq = 8'd0;
    drain();

    // Tightest useful limit: most gaps get clipped.
    write_max_gap(16'd1);
    queue_random(300);
    drain();

    // Widest limit, with both sides running without gaps.
    write_max_gap(16'hffff);
    no_gaps = 1'b1;
    queue_random(400);
    drain();
    no_gaps = 1'b0;

    // Zero limit: every nonzero gap reads as 0.
    write_max_gap(16'd0);
    queue_random(200);
    drain();

    write_max_gap(16'd3);
    queue_random(300);
    drain();

    write_max_gap(MaxGapReset);
    queue_random(500);

    // Let any short scheduled change expire, then a maximum delay that stays
    // pending to the end, so later messages are refused.
    repeat (160) link_item_q.push_back(link_item(KindTick, 1'b0, 8'd0, 8'd0, 16'd0));
    link_item_q.push_back(link_item(KindRx,   1'b0, gen_seq + 8'd1, RxToOn,  16'hffff));
    link_item_q.push_back(link_item(KindRx,   1'b0, gen_seq + 8'd2, RxQuery, 16'd0));
    link_item_q.push_back(link_item(KindTick, 1'b0, 8'd0, 8'd0, 16'd0));
    link_item_q.push_back(link_item(KindRx,   1'b0, gen_seq + 8'd3, RxIsOff, 16'd0));
    drain();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && link_result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ktl_pkg.sv
sv/ktl_stream_if.sv
sv/ktl_front.sv
sv/ktl_queue.sv
sv/ktl_back.sv
sv/key_timing_link_controller_core.sv
tb/sv/key_timing_link_controller_core_tb.sv
